/* rtl/assert_macros.svh */
// Assertion macros for the double-ended queue checkers.
// No dependencies; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define DEQS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define DEQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/deqs_pkg.sv */
// Package for the double-ended queue with search: sizes, codes, word types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package deqs_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_FIND       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_MATCH,
    CMD_SHIFT_MATCH
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [4:0]         found_index;
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [VALUE_BITS-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] front_data;
    logic                  front_live;
    logic                  head_match;
    logic [VALUE_BITS-1:0] back_data;
  } chain_sts_t;

  function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [31:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[VALUE_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] to_out(input logic [VALUE_BITS-1:0] s);
    logic signed [VALUE_BITS-1:0] t;
    logic signed [63:0]           e;
    t = s;
    e = 64'(t);
    return e[31:0];
  endfunction

endpackage

/* rtl/double_ended_queue_with_search_core.sv */
// Bounded double-ended queue of signed words with a search by value. A push or
// pop is accepted only while idle; its result is loaded into the output register
// in the report state, and no new word is taken before that. A search loads a match
// flag into every cell, then walks the flags toward the front one cell a cycle
// until cell 0 holds a match or the scan reaches the count. The report cycle
// waits while an earlier result is still held on the output.
// Depends on deqs_pkg and deqs_chain.
`timescale 1ns / 1ps

module double_ended_queue_with_search_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  deqs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output deqs_pkg::out_t out_data
);

  localparam int CW = deqs_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        scan_r;
  logic signed [31:0]   front_r, back_r, popped_r;
  logic [CW-1:0]        found_r;
  deqs_pkg::status_t    status_r;
  logic                 out_valid_r;
  deqs_pkg::out_t       out_r;

  deqs_pkg::cell_ctl_t  ctl;
  deqs_pkg::chain_sts_t sts;
  logic                 accept, full, empty, scan_done;
  logic signed [31:0]   front_new;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CW'(deqs_pkg::CAPACITY));
  assign empty     = (count_r == '0);
  assign scan_done = sts.head_match || (scan_r == count_r);

  always_comb begin
    ctl.key = deqs_pkg::to_store(in_data.value);
    ctl.cmd = deqs_pkg::CMD_HOLD;
    if (accept) begin
      case (in_data.action)
        deqs_pkg::ACT_PUSH_FRONT: if (!full)  ctl.cmd = deqs_pkg::CMD_PUSH_FRONT;
        deqs_pkg::ACT_PUSH_BACK:  if (!full)  ctl.cmd = deqs_pkg::CMD_PUSH_BACK;
        deqs_pkg::ACT_POP_FRONT:  if (!empty) ctl.cmd = deqs_pkg::CMD_POP_FRONT;
        deqs_pkg::ACT_POP_BACK:   if (!empty) ctl.cmd = deqs_pkg::CMD_POP_BACK;
        deqs_pkg::ACT_FIND:       ctl.cmd = deqs_pkg::CMD_MATCH;
        default: ;
      endcase
    end else if (state_r == S_SCAN && !scan_done) begin
      ctl.cmd = deqs_pkg::CMD_SHIFT_MATCH;
    end
  end

  deqs_chain u_chain (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .sts  (sts)
  );

  assign front_new = sts.front_live ? deqs_pkg::to_out(sts.front_data) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_REPORT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready)                                     out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            scan_r <= '0;
            case (in_data.action)
              deqs_pkg::ACT_PUSH_FRONT, deqs_pkg::ACT_PUSH_BACK: begin
                state_r <= S_REPORT;
                if (!full) count_r <= count_r + CW'(1);
              end
              deqs_pkg::ACT_POP_FRONT, deqs_pkg::ACT_POP_BACK: begin
                state_r <= S_REPORT;
                if (!empty) count_r <= count_r - CW'(1);
              end
              deqs_pkg::ACT_FIND: state_r <= S_SCAN;
              default: state_r <= S_REPORT;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_done) state_r <= S_REPORT;
          else           scan_r  <= scan_r + CW'(1);
        end
        S_REPORT: begin
          if (!out_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          found_r <= '0;
          case (in_data.action)
            deqs_pkg::ACT_PUSH_FRONT, deqs_pkg::ACT_PUSH_BACK: begin
              popped_r <= '0;
              status_r <= full ? deqs_pkg::ST_FULL : deqs_pkg::ST_OK;
            end
            deqs_pkg::ACT_POP_FRONT: begin
              popped_r <= empty ? '0 : front_r;
              status_r <= empty ? deqs_pkg::ST_EMPTY : deqs_pkg::ST_OK;
            end
            deqs_pkg::ACT_POP_BACK: begin
              popped_r <= empty ? '0 : back_r;
              status_r <= empty ? deqs_pkg::ST_EMPTY : deqs_pkg::ST_OK;
            end
            default: begin
              popped_r <= '0;
              status_r <= deqs_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) found_r <= scan_r;
      end
      S_REPORT: begin
        front_r <= front_new;
        back_r  <= deqs_pkg::to_out(sts.back_data);
        if (!out_valid_r || out_ready) begin
          out_r.popped_value <= popped_r;
          out_r.found_index  <= 5'(found_r);
          out_r.status       <= status_r;
          out_r.count        <= 5'(count_r);
          out_r.front_value  <= front_new;
          out_r.back_value   <= deqs_pkg::to_out(sts.back_data);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/deqs_cell.sv */
// One storage cell of the queue row: word, live flag and search match flag.
// Depends on deqs_pkg; instanced by deqs_chain.
`timescale 1ns / 1ps

module deqs_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  deqs_pkg::cell_ctl_t              ctl,
  input  logic [deqs_pkg::VALUE_BITS-1:0]  left_data,
  input  logic                             left_live,
  input  logic [deqs_pkg::VALUE_BITS-1:0]  right_data,
  input  logic                             right_live,
  input  logic                             right_match,
  output logic [deqs_pkg::VALUE_BITS-1:0]  data,
  output logic                             live,
  output logic                             match,
  output logic [deqs_pkg::VALUE_BITS-1:0]  tail_data
);

  logic [deqs_pkg::VALUE_BITS-1:0] data_r;
  logic                            live_r;
  logic                            match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      case (ctl.cmd)
        deqs_pkg::CMD_PUSH_FRONT:  live_r  <= left_live;
        deqs_pkg::CMD_PUSH_BACK:   live_r  <= live_r | left_live;
        deqs_pkg::CMD_POP_FRONT:   live_r  <= right_live;
        deqs_pkg::CMD_POP_BACK:    live_r  <= right_live;
        deqs_pkg::CMD_MATCH:       match_r <= live_r && (data_r == ctl.key);
        deqs_pkg::CMD_SHIFT_MATCH: match_r <= right_match;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      deqs_pkg::CMD_PUSH_FRONT: data_r <= left_data;
      deqs_pkg::CMD_POP_FRONT:  data_r <= right_data;
      deqs_pkg::CMD_PUSH_BACK: begin
        if (!live_r && left_live) data_r <= ctl.key;
      end
      default: ;
    endcase
  end

  assign data      = data_r;
  assign live      = live_r;
  assign match     = match_r;
  assign tail_data = (live_r && !right_live) ? data_r : '0;

endmodule

/* rtl/deqs_chain.sv */
// Row of queue cells, front at cell 0; selects the back word from the tail cell.
// Depends on deqs_pkg and deqs_cell.
`timescale 1ns / 1ps

module deqs_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  deqs_pkg::cell_ctl_t  ctl,
  output deqs_pkg::chain_sts_t sts
);

  localparam int N  = deqs_pkg::CAPACITY;
  localparam int VB = deqs_pkg::VALUE_BITS;

  logic [VB-1:0] data_w  [N];
  logic [VB-1:0] tail_w  [N];
  logic          live_w  [N];
  logic          match_w [N];
  logic [VB-1:0] back_w;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [VB-1:0] l_data, r_data;
    logic          l_live, r_live, r_match;

    if (i == 0) begin : g_head
      assign l_data = ctl.key;
      assign l_live = 1'b1;
    end else begin : g_mid
      assign l_data = data_w[i-1];
      assign l_live = live_w[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_data  = '0;
      assign r_live  = 1'b0;
      assign r_match = 1'b0;
    end else begin : g_body
      assign r_data  = data_w[i+1];
      assign r_live  = live_w[i+1];
      assign r_match = match_w[i+1];
    end

    deqs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_data  (l_data),
      .left_live  (l_live),
      .right_data (r_data),
      .right_live (r_live),
      .right_match(r_match),
      .data       (data_w[i]),
      .live       (live_w[i]),
      .match      (match_w[i]),
      .tail_data  (tail_w[i])
    );
  end

  always_comb begin
    back_w = '0;
    for (int i = 0; i < N; i++) back_w = back_w | tail_w[i];
  end

  assign sts.front_data = data_w[0];
  assign sts.front_live = live_w[0];
  assign sts.head_match = match_w[0];
  assign sts.back_data  = back_w;

endmodule

/* rtl/deqs_checker.sv */
// Port-level checker for the double-ended queue with search, bound to the top.
// Depends on deqs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deqs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input deqs_pkg::out_t out_data
);

  `DEQS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word dropped or changed while stalled")
  `DEQS_ASSERT(a_empty_pop, clk, rst_n, out_valid && out_data.status == deqs_pkg::ST_EMPTY |-> out_data.count == 5'd0 && out_data.popped_value == 32'sd0, "pop on empty reports data")
  `DEQS_ASSERT(a_empty_ends, clk, rst_n, out_valid && out_data.count == 5'd0 |-> out_data.front_value == 32'sd0 && out_data.back_value == 32'sd0, "empty queue reports end words")
  `DEQS_ASSERT(a_full_cnt, clk, rst_n, out_valid && out_data.status == deqs_pkg::ST_FULL |-> out_data.count == 5'(deqs_pkg::CAPACITY), "full status with queue not full")
  `DEQS_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result word valid after reset")

endmodule

bind double_ended_queue_with_search_core deqs_checker u_deqs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* sim/tb_double_ended_queue_with_search_core.sv */
// Testbench for double_ended_queue_with_search_core: pushes, pops, searches and stray codes,
// each word's result checked against a predicted deque that runs beside the block.
// Depends on deqs_pkg and the block's RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_double_ended_queue_with_search_core;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  deqs_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  deqs_pkg::out_t out_data;

  logic signed [31:0] deque_model[$];
  deqs_pkg::out_t     expected_results[$];
  int unsigned        mismatches;
  int unsigned        idle_cycles;
  int unsigned        rx_hold;
  int unsigned        rx_stall;
  bit                 gaps_on;

  double_ended_queue_with_search_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic deqs_pkg::out_t predict_word(input deqs_pkg::in_t w);
    deqs_pkg::out_t r;
    r = '0;
    case (w.action)
      deqs_pkg::ACT_PUSH_FRONT: begin
        if (deque_model.size() >= deqs_pkg::CAPACITY) r.status = deqs_pkg::ST_FULL;
        else deque_model.push_front(w.value);
      end
      deqs_pkg::ACT_PUSH_BACK: begin
        if (deque_model.size() >= deqs_pkg::CAPACITY) r.status = deqs_pkg::ST_FULL;
        else deque_model.push_back(w.value);
      end
      deqs_pkg::ACT_POP_FRONT: begin
        if (deque_model.size() == 0) r.status = deqs_pkg::ST_EMPTY;
        else begin
          r.popped_value = deque_model[0];
          deque_model.delete(0);
        end
      end
      deqs_pkg::ACT_POP_BACK: begin
        if (deque_model.size() == 0) r.status = deqs_pkg::ST_EMPTY;
        else begin
          r.popped_value = deque_model[deque_model.size() - 1];
          deque_model.delete(deque_model.size() - 1);
        end
      end
      deqs_pkg::ACT_FIND: begin
        r.found_index = 5'(deque_model.size());
        for (int i = deque_model.size() - 1; i >= 0; i--) begin
          if (deque_model[i] == w.value) r.found_index = 5'(i);
        end
      end
      default: begin
      end
    endcase
    r.count = 5'(deque_model.size());
    if (deque_model.size() != 0) begin
      r.front_value = deque_model[0];
      r.back_value  = deque_model[deque_model.size() - 1];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: return 32'($urandom_range(1, 4));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [2:0] act, input logic signed [31:0] val);
    deqs_pkg::in_t w;
    int unsigned   gap;
    w.action = act;
    w.value  = val;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_word(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic random_words(input int n, input int push_bias);
    int                 r;
    logic [2:0]         act;
    logic signed [31:0] val;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      val = pick_value();
      if (r < 3) begin
        act = 3'($urandom_range(5, 7));
      end else if (r < 28) begin
        act = deqs_pkg::ACT_FIND;
        if (r < 12 && deque_model.size() != 0)
          val = deque_model[$urandom_range(0, deque_model.size() - 1)];
      end else if ($urandom_range(0, 99) < push_bias) begin
        act = $urandom_range(0, 1) ? deqs_pkg::ACT_PUSH_BACK : deqs_pkg::ACT_PUSH_FRONT;
      end else begin
        act = $urandom_range(0, 1) ? deqs_pkg::ACT_POP_BACK : deqs_pkg::ACT_POP_FRONT;
      end
      send_word(act, val);
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b1;
    send_word(deqs_pkg::ACT_FIND, 32'sd5);
    send_word(deqs_pkg::ACT_POP_FRONT, 32'sd0);
    send_word(deqs_pkg::ACT_POP_BACK, 32'sd0);
    send_word(3'd5, 32'sd1);
    send_word(3'd6, -32'sd1);
    send_word(3'd7, 32'sh7fff_ffff);
    send_word(deqs_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff);
    send_word(deqs_pkg::ACT_PUSH_BACK, 32'sh8000_0000);
    send_word(deqs_pkg::ACT_POP_FRONT, 32'sd0);
    send_word(deqs_pkg::ACT_POP_BACK, 32'sd0);
    // fill to capacity from both ends
    for (int i = 0; i < deqs_pkg::CAPACITY; i++) begin
      case (i % 4)
        0: send_word(deqs_pkg::ACT_PUSH_BACK, 32'sh8000_0000);
        1: send_word(deqs_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff);
        2: send_word(deqs_pkg::ACT_PUSH_BACK, -32'sd1);
        default: send_word(deqs_pkg::ACT_PUSH_FRONT, 32'(i));
      endcase
    end
    send_word(deqs_pkg::ACT_PUSH_FRONT, 32'sd42);
    send_word(deqs_pkg::ACT_PUSH_BACK, 32'sd42);
    send_word(deqs_pkg::ACT_FIND, 32'(deqs_pkg::CAPACITY - 2));
    send_word(deqs_pkg::ACT_FIND, 32'sd42);
    wait_drained();
  endtask

  task automatic test_random();
    gaps_on = 1'b1;
    random_words(60, 70);
    random_words(60, 30);
    random_words(50, 80);
    random_words(50, 20);
    wait_drained();
  endtask

  task automatic test_back_pressure();
    gaps_on = 1'b0;
    rx_hold = 80;
    random_words(40, 75);
    wait_drained();
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    random_words(40, 65);
    random_words(40, 35);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    gaps_on = 1'b1;
    random_words(20, 60);
    wait_drained();
    random_words(20, 40);
    wait_drained();
  endtask

  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    deqs_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        report_field("popped_value", e.popped_value, out_data.popped_value);
        report_field("found_index", e.found_index, out_data.found_index);
        report_field("status", e.status, out_data.status);
        report_field("count", e.count, out_data.count);
        report_field("front_value", e.front_value, out_data.front_value);
        report_field("back_value", e.back_value, out_data.back_value);
      end
    end
  end

  // receiver: random stall per word while gaps are on, long hold on request
  always @(posedge clk) begin
    if (out_valid && out_ready && rx_stall == 0 && gaps_on) rx_stall = $urandom_range(0, 10);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    rx_hold    = 0;
    rx_stall   = 0;
    gaps_on    = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_back_pressure();
    test_no_gaps();
    test_sender_pause();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
